/* hdl/point_mass_env_step_core_defines.svh */
// Assertion macros shared by the point-mass environment checker.
`ifndef POINT_MASS_ENV_STEP_CORE_DEFINES_SVH
`define POINT_MASS_ENV_STEP_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PMES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmes checker: property violated");

// Consequent must hold in the same cycle as the antecedent.
`define PMES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmes checker: property violated");

`endif

/* hdl/pmes_pkg.sv */
// Shared constants, types and arithmetic helpers of the point-mass environment core.
package pmes_pkg;

  // Largest grid size and the integration time step in Q16.16.
  localparam int MAX_POINTS  = 256;
  localparam int TIME_STEP_Q = 655;

  // Grid index width and the width of the nearest-point search arithmetic.
  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int SRCH_W = PT_W + 36;

  // Shared divider: dividend and divisor widths, iteration counter width.
  localparam int DIV_DW = 79;
  localparam int DIV_VW = 63;
  localparam int DIV_CW = $clog2(DIV_DW + 1);

  // Configuration address width (eight 32-bit registers).
  localparam int CFG_AW = 5;

  // Register indexes.
  localparam logic [2:0] REG_POS_LOW     = 3'd0;
  localparam logic [2:0] REG_POS_HIGH    = 3'd1;
  localparam logic [2:0] REG_VEL_LOW     = 3'd2;
  localparam logic [2:0] REG_VEL_HIGH    = 3'd3;
  localparam logic [2:0] REG_START_POS   = 3'd4;
  localparam logic [2:0] REG_POS_POINTS  = 3'd5;
  localparam logic [2:0] REG_VEL_POINTS  = 3'd6;
  localparam logic [2:0] REG_REWARD_MODE = 3'd7;

  // Reward modes.
  localparam logic [1:0] RM_ENDS = 2'd0;
  localparam logic [1:0] RM_DIST = 2'd1;
  localparam logic [1:0] RM_NORM = 2'd2;

  // Command codes.
  localparam logic CMD_RESET = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Fixed values.
  localparam logic signed [31:0] S32_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN   = 32'sh80000000;
  localparam logic signed [31:0] RWD_ENDS  = 32'shFFFF0000;
  localparam logic signed [39:0] SAT_HI    = 40'sh007FFFFFFF;
  localparam logic signed [39:0] SAT_LO    = 40'shFF80000000;

  // Configuration register set.
  typedef struct packed {
    logic signed [31:0] pos_low;
    logic signed [31:0] pos_high;
    logic signed [31:0] vel_low;
    logic signed [31:0] vel_high;
    logic signed [31:0] start_pos;
    logic [8:0]         pos_points;
    logic [8:0]         vel_points;
    logic [1:0]         reward_mode;
  } pmes_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic vel_en;
    logic pos_en;
    logic prep_en;
    logic div_start;
    logic rew1_en;
    logic rew2_en;
    logic out_load;
  } pmes_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic srch_done;
    logic div_done;
  } pmes_sts_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = S32_MAX;
    end else if (v < SAT_LO) begin
      r = S32_MIN;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Multiply by the time step, rounding toward minus infinity.
  function automatic logic signed [39:0] mul_dt(input logic signed [31:0] a);
    logic signed [63:0] prod;
    prod = 64'(a) * 64'(TIME_STEP_Q);
    return 40'(prod >>> 16);
  endfunction

  // Clamp a configured point count to the supported range.
  function automatic logic [PT_W:0] clamp_pts(input logic [8:0] n);
    logic [PT_W:0] r;
    if (n < 9'd2) begin
      r = (PT_W + 1)'(2);
    end else if (32'(n) > MAX_POINTS) begin
      r = (PT_W + 1)'(MAX_POINTS);
    end else begin
      r = (PT_W + 1)'(n);
    end
    return r;
  endfunction

endpackage

/* hdl/pmes_nearest.sv */
// Nearest grid point search, one grid point per cycle.
module pmes_nearest (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [31:0]          x,
  input  logic signed [31:0]          low,
  input  logic signed [31:0]          high,
  input  logic [8:0]                  n_raw,
  output logic [pmes_pkg::PT_W-1:0]   idx,
  output logic                        done
);
  import pmes_pkg::*;

  logic signed [32:0]       span_d;
  logic signed [33:0]       rel;
  logic signed [PT_W:0]     nm1_s;
  logic [PT_W-1:0]          nm1;
  logic signed [SRCH_W-1:0] off;
  logic signed [SRCH_W-1:0] span;
  logic signed [SRCH_W-1:0] diff;
  logic [SRCH_W-1:0]        dabs;

  logic signed [SRCH_W-1:0] off_r;
  logic signed [SRCH_W-1:0] span_r;
  logic signed [SRCH_W-1:0] acc_r;
  logic [SRCH_W-1:0]        bestd_r;
  logic [PT_W-1:0]          i_r;
  logic [PT_W-1:0]          last_r;
  logic [PT_W-1:0]          best_r;
  logic                     busy_r;
  logic                     done_r;

  // Grid spacing numerator and scaled offset of x from the first point.
  always_comb begin
    span_d = 33'(high) - 33'(low);
    span   = (span_d < 0) ? SRCH_W'(-span_d) : SRCH_W'(span_d);
    nm1    = PT_W'(clamp_pts(n_raw) - 1'b1);
    nm1_s  = $signed({1'b0, nm1});
    rel    = 34'(x) - 34'(low);
    off    = rel * nm1_s;
  end

  // Distance from x to the candidate point, both scaled by n-1.
  always_comb begin
    diff = off_r - acc_r;
    dabs = (diff < 0) ? SRCH_W'(-diff) : SRCH_W'(diff);
  end

  // Walk the grid; a strictly smaller distance wins, so ties stay low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (i_r == last_r)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      off_r   <= off;
      span_r  <= span;
      acc_r   <= '0;
      i_r     <= '0;
      last_r  <= nm1;
      bestd_r <= '1;
    end else if (busy_r) begin
      if (dabs < bestd_r) begin
        bestd_r <= dabs;
        best_r  <= i_r;
      end
      i_r   <= i_r + 1'b1;
      acc_r <= acc_r + span_r;
    end
  end

  assign idx  = best_r;
  assign done = done_r;

endmodule

/* hdl/pmes_div.sv */
// Restoring divider, one quotient bit per cycle.
module pmes_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pmes_pkg::DIV_DW-1:0]   dividend,
  input  logic [pmes_pkg::DIV_VW-1:0]   divisor,
  output logic [pmes_pkg::DIV_DW-1:0]   quot,
  output logic                          done
);
  import pmes_pkg::*;

  logic [DIV_DW-1:0] q_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_VW:0]   trial;
  logic              qbit;

  // Shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_r, q_r[DIV_DW-1]};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  // Control: iteration count and completion flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CW'(DIV_DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_DW-2:0], qbit};
      rem_r <= qbit ? DIV_VW'(trial - {1'b0, dvs_r}) : DIV_VW'(trial);
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

/* hdl/pmes_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
module pmes_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pmes_pkg::pmes_cmd_t   cmd,
  input  pmes_pkg::pmes_sts_t   sts
);
  import pmes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VEL, S_POS, S_PREP, S_DIVS, S_RUN, S_REW1, S_REW2, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath commands.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        cmd.vel_en = 1'b1;
        state_nxt  = S_POS;
      end
      S_POS: begin
        cmd.pos_en = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep_en = 1'b1;
        state_nxt   = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RUN;
      end
      S_RUN: begin
        if (sts.srch_done && sts.div_done) begin
          state_nxt = S_REW1;
        end
      end
      S_REW1: begin
        cmd.rew1_en = 1'b1;
        state_nxt   = S_REW2;
      end
      S_REW2: begin
        cmd.rew2_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/pmes_dp.sv */
// Datapath: integration, bounds check, grid searches, reward and result registers.
module pmes_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmes_pkg::pmes_cmd_t   cmd,
  output pmes_pkg::pmes_sts_t   sts,
  input  pmes_pkg::pmes_cfg_t   cfg,
  input  logic                  in_command,
  input  logic signed [31:0]    in_accel,
  output logic                  out_done_res,
  output logic [15:0]           out_state_index,
  output logic signed [31:0]    out_reward
);
  import pmes_pkg::*;

  localparam int MW = 44;
  localparam int N1_W = 33 + PT_W;

  // Transaction and body state.
  logic               cmd_r;
  logic signed [31:0] accel_r;
  logic signed [31:0] cur_p_r;
  logic signed [31:0] cur_v_r;
  logic               done_r;

  // Reward precomputation.
  logic [DIV_VW-1:0]  h2_r;
  logic [DIV_VW-1:0]  p2_r;
  logic [N1_W-1:0]    num1_r;
  logic               neg_r;
  logic [MW-1:0]      d_r;
  logic               dbig_r;
  logic [15:0]        sidx_r;
  logic signed [31:0] reward_r;

  logic signed [63:0] hh;
  logic signed [63:0] pp;
  logic signed [32:0] span_d;
  logic [32:0]        span_p;
  logic [PT_W:0]      np;
  logic [PT_W:0]      nv;
  logic [PT_W-1:0]    nm1_p;
  logic [PT_W-1:0]    half_p;
  logic               out_rng;

  logic               neg;
  logic [DIV_VW-1:0]  num2;
  logic [DIV_DW-1:0]  dvd;
  logic [DIV_VW-1:0]  dvs;
  logic [DIV_DW-1:0]  quot;
  logic               div_done;

  logic [PT_W-1:0]    pidx;
  logic [PT_W-1:0]    vidx;
  logic               pdone;
  logic               vdone;
  logic               srch_go;

  logic signed [MW-1:0] m;
  logic signed [MW-1:0] dd;
  logic [2*PT_W+1:0]    sidx_full;
  logic [47:0]          sq;
  logic [31:0]          sqv;
  logic signed [31:0]   rew_dist;
  logic signed [31:0]   rew_norm;
  logic signed [31:0]   rew_ends;
  logic [31:0]          qlo;

  // Grid and reward terms that follow from configuration and position.
  always_comb begin
    hh      = cfg.pos_high * cfg.pos_high;
    pp      = cur_p_r * cur_p_r;
    span_d  = 33'(cfg.pos_high) - 33'(cfg.pos_low);
    span_p  = (span_d < 0) ? 33'(-span_d) : 33'(span_d);
    np      = clamp_pts(cfg.pos_points);
    nv      = clamp_pts(cfg.vel_points);
    nm1_p   = PT_W'(np - 1'b1);
    half_p  = PT_W'(np >> 1);
    out_rng = (cur_p_r < cfg.pos_low) || (cur_p_r > cfg.pos_high) ||
              (cur_v_r < cfg.vel_low) || (cur_v_r > cfg.vel_high);
  end

  // Divider operands: middle point for distance mode, ratio for the normalized mode.
  always_comb begin
    neg  = (p2_r > h2_r);
    num2 = neg ? (p2_r - h2_r) : (h2_r - p2_r);
    if (cfg.reward_mode == RM_DIST) begin
      dvd = DIV_DW'(num1_r);
      dvs = DIV_VW'(nm1_p);
    end else begin
      dvd = {num2, 16'h0000};
      dvs = h2_r;
    end
  end

  // Integration, transaction capture and precomputation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_p_r <= '0;
      cur_v_r <= '0;
    end else if (cmd.vel_en) begin
      if (cmd_r == CMD_STEP) begin
        cur_v_r <= sat32(40'(cur_v_r) + mul_dt(accel_r));
      end else begin
        cur_v_r <= '0;
        cur_p_r <= cfg.start_pos;
      end
    end else if (cmd.pos_en && (cmd_r == CMD_STEP)) begin
      cur_p_r <= sat32(40'(cur_p_r) + mul_dt(cur_v_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      accel_r <= in_accel;
    end
    if (cmd.prep_en) begin
      done_r <= (cmd_r == CMD_STEP) && out_rng;
      h2_r   <= hh[DIV_VW-1:0];
      p2_r   <= pp[DIV_VW-1:0];
      num1_r <= N1_W'(half_p) * N1_W'(span_p);
    end
    if (cmd.div_start) begin
      neg_r <= neg;
    end
  end

  // Nearest grid point of position and velocity, searched side by side.
  assign srch_go = cmd.prep_en;

  pmes_nearest u_pos_srch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_go),
    .x     (cur_p_r),
    .low   (cfg.pos_low),
    .high  (cfg.pos_high),
    .n_raw (cfg.pos_points),
    .idx   (pidx),
    .done  (pdone)
  );

  pmes_nearest u_vel_srch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_go),
    .x     (cur_v_r),
    .low   (cfg.vel_low),
    .high  (cfg.vel_high),
    .n_raw (cfg.vel_points),
    .idx   (vidx),
    .done  (vdone)
  );

  pmes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .done     (div_done)
  );

  assign sts.srch_done = pdone & vdone;
  assign sts.div_done  = div_done;

  // First reward stage: distance to the middle point and the state index.
  always_comb begin
    m         = MW'(cfg.pos_low) + $signed({1'b0, quot[MW-2:0]});
    dd        = MW'(cur_p_r) - m;
    sidx_full = pidx * nv + vidx;
  end

  always_ff @(posedge clk) begin
    if (cmd.rew1_en) begin
      d_r    <= (dd < 0) ? MW'(-dd) : MW'(dd);
      dbig_r <= (dd >= MW'(1 << 24)) || (dd <= -MW'(1 << 24));
      sidx_r <= sidx_full[15:0];
    end
  end

  // Second reward stage: final value for each mode.
  always_comb begin
    sq       = d_r[23:0] * d_r[23:0];
    sqv      = sq[47:16];
    rew_dist = (dbig_r || sqv[31]) ? S32_MIN : $signed(32'(0) - sqv);
    qlo      = quot[31:0];
    if (h2_r == '0) begin
      rew_norm = '0;
    end else if (|quot[DIV_DW-1:31]) begin
      rew_norm = neg_r ? S32_MIN : S32_MAX;
    end else begin
      rew_norm = neg_r ? $signed(32'(0) - qlo) : $signed(qlo);
    end
    rew_ends = ((cur_p_r >= cfg.pos_high) || (cur_p_r <= cfg.pos_low)) ? RWD_ENDS : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rew2_en) begin
      case (cfg.reward_mode)
        RM_ENDS: reward_r <= rew_ends;
        RM_DIST: reward_r <= rew_dist;
        RM_NORM: reward_r <= rew_norm;
        default: reward_r <= '0;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_done_res    <= done_r;
      out_state_index <= sidx_r;
      out_reward      <= reward_r;
    end
  end

endmodule

/* hdl/point_mass_env_step_core.sv */
// Top level of the point-mass environment step core with its register file.
//
//  channel   direction  transaction                       handshake
//  in_       input      command, accel                    in_valid / in_stall
//  out_      output     done_res, state_index, reward     out_valid / out_stall
//  config    input      register write / read             psel, penable, pwrite
//
// The output register is loaded after the accepting edge once the datapath has passed
// through the velocity, position, precompute and divider-start states, waited for the
// bit-serial divider and the two grid walks (one point per cycle), and passed the two
// reward states. One transaction is in flight at a time; a finished result
// waits in the output register while the next transaction is accepted.
// Reset is synchronous, active low, and loads the register defaults.
module point_mass_env_step_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [31:0]            in_accel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_done_res,
  output logic [15:0]                   out_state_index,
  output logic signed [31:0]            out_reward,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmes_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pmes_pkg::*;

  pmes_cfg_t  cfg_r;
  pmes_cmd_t  cmd;
  pmes_sts_t  sts;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_low     <= 32'shFFFF0000;
      cfg_r.pos_high    <= 32'sh00010000;
      cfg_r.vel_low     <= 32'shFFFF0000;
      cfg_r.vel_high    <= 32'sh00010000;
      cfg_r.start_pos   <= '0;
      cfg_r.pos_points  <= 9'd16;
      cfg_r.vel_points  <= 9'd16;
      cfg_r.reward_mode <= RM_ENDS;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_POS_LOW:     cfg_r.pos_low     <= pwdata;
        REG_POS_HIGH:    cfg_r.pos_high    <= pwdata;
        REG_VEL_LOW:     cfg_r.vel_low     <= pwdata;
        REG_VEL_HIGH:    cfg_r.vel_high    <= pwdata;
        REG_START_POS:   cfg_r.start_pos   <= pwdata;
        REG_POS_POINTS:  cfg_r.pos_points  <= pwdata[8:0];
        REG_VEL_POINTS:  cfg_r.vel_points  <= pwdata[8:0];
        REG_REWARD_MODE: cfg_r.reward_mode <= pwdata[1:0];
        default:         cfg_r.reward_mode <= cfg_r.reward_mode;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_POS_LOW:     prdata = cfg_r.pos_low;
      REG_POS_HIGH:    prdata = cfg_r.pos_high;
      REG_VEL_LOW:     prdata = cfg_r.vel_low;
      REG_VEL_HIGH:    prdata = cfg_r.vel_high;
      REG_START_POS:   prdata = cfg_r.start_pos;
      REG_POS_POINTS:  prdata = 32'(cfg_r.pos_points);
      REG_VEL_POINTS:  prdata = 32'(cfg_r.vel_points);
      REG_REWARD_MODE: prdata = 32'(cfg_r.reward_mode);
      default:         prdata = '0;
    endcase
  end

  pmes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pmes_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg_r),
    .in_command      (in_command),
    .in_accel        (in_accel),
    .out_done_res    (out_done_res),
    .out_state_index (out_state_index),
    .out_reward      (out_reward)
  );

endmodule

/* hdl/pmes_checker.sv */
// Port-level checker for the point-mass environment core and its bind.
`include "point_mass_env_step_core_defines.svh"

module pmes_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_command,
  input logic signed [31:0]            in_accel,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_done_res,
  input logic [15:0]                   out_state_index,
  input logic signed [31:0]            out_reward,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [pmes_pkg::CFG_AW-1:0]   paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);

  // A stalled result keeps its valid and its payload.
  `PMES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_reward) && $stable(out_state_index) && $stable(out_done_res))

  // Only one transaction is in flight: the input stalls right after acceptance.
  `PMES_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

  // A new result appears only at the end of a busy period.
  `PMES_ASSERT_NOW(a_res_after_busy, $rose(out_valid), $past(in_stall))

  // The input frees up exactly when a result has been placed in the output register.
  `PMES_ASSERT_NOW(a_free_with_result, $fell(in_stall), out_valid)

endmodule

bind point_mass_env_step_core pmes_checker u_pmes_checker (.*);

/* bench/point_mass_env_step_core_tb.sv */
// Self-checking testbench for the point-mass environment step core.
`timescale 1ns / 100ps

module point_mass_env_step_core_tb;
  import pmes_pkg::*;

  // Kinds of rows in the directed table.
  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        cmd;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    logic        typed;
    logic        done_res;
    logic [15:0] state_index;
    logic [31:0] reward;
  } dir_row_t;

  typedef struct packed {
    logic        done_res;
    logic [15:0] state_index;
    logic [31:0] reward;
  } env_result_t;

  localparam int NUM_DIR = 26;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_command;
  logic signed [31:0] in_accel;
  logic out_valid, out_stall, out_done_res;
  logic [15:0] out_state_index;
  logic signed [31:0] out_reward;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  // Model state: registers, body position and velocity.
  logic [31:0] reg_file [8];
  longint body_pos, body_vel;

  env_result_t pending_results[$];
  int errors;
  int tx_idle_pct, rx_stall_pct;

  point_mass_env_step_core u_top (.*);

  // Clock generation.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sat_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pts_used(input logic [31:0] n);
    if (n < 2) return 2;
    if (n > MAX_POINTS) return MAX_POINTS;
    return longint'(n);
  endfunction

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Nearest grid point, ties to the lower index.
  function automatic longint grid_index(input longint x, input longint lo, input longint hi,
                                        input longint n);
    longint span, off, best, bestd, d;
    span = abs_l(hi - lo);
    off = (x - lo) * (n - 1);
    best = 0;
    bestd = abs_l(off);
    for (longint i = 1; i < n; i++) begin
      d = abs_l(off - i * span);
      if (d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // Reward for a position under the current mode.
  function automatic longint reward_for(input longint p);
    longint lo, hi, n, m, d;
    longint unsigned h2, p2, num, ip, r, frac;
    logic neg;
    lo = sx(reg_file[REG_POS_LOW]);
    hi = sx(reg_file[REG_POS_HIGH]);
    case (reg_file[REG_REWARD_MODE][1:0])
      RM_ENDS: return (p >= hi || p <= lo) ? -64'sd65536 : 0;
      RM_DIST: begin
        n = pts_used(reg_file[REG_POS_POINTS]);
        m = lo + ((n / 2) * abs_l(hi - lo)) / (n - 1);
        d = abs_l(p - m);
        if (d >= (64'sd1 << 24)) return -64'sd2147483648;
        return sat_s32(-((d * d) / 65536));
      end
      RM_NORM: begin
        h2 = hi * hi;
        p2 = p * p;
        if (h2 == 0) return 0;
        neg = p2 > h2;
        num = neg ? p2 - h2 : h2 - p2;
        ip = num / h2;
        r = num % h2;
        frac = 0;
        for (int k = 0; k < 16; k++) begin
          r = r << 1;
          frac = frac << 1;
          if (r >= h2) begin
            r = r - h2;
            frac = frac | 1;
          end
        end
        if (ip >= 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return sat_s32(neg ? -longint'((ip << 16) | frac) : longint'((ip << 16) | frac));
      end
      default: return 0;
    endcase
  endfunction

  // Advance the body by one command and work out the result.
  function automatic env_result_t advance_body(input logic cmd, input logic [31:0] accel);
    env_result_t res;
    longint nv, np, pi, vi;
    res.done_res = 1'b0;
    if (cmd == CMD_RESET) begin
      body_pos = sx(reg_file[REG_START_POS]);
      body_vel = 0;
    end else begin
      nv = sat_s32(body_vel + ((sx(accel) * TIME_STEP_Q) >>> 16));
      np = sat_s32(body_pos + ((nv * TIME_STEP_Q) >>> 16));
      body_vel = nv;
      body_pos = np;
      if (np < sx(reg_file[REG_POS_LOW]) || np > sx(reg_file[REG_POS_HIGH])) res.done_res = 1'b1;
      if (nv < sx(reg_file[REG_VEL_LOW]) || nv > sx(reg_file[REG_VEL_HIGH])) res.done_res = 1'b1;
    end
    np = pts_used(reg_file[REG_POS_POINTS]);
    nv = pts_used(reg_file[REG_VEL_POINTS]);
    pi = grid_index(body_pos, sx(reg_file[REG_POS_LOW]), sx(reg_file[REG_POS_HIGH]), np);
    vi = grid_index(body_vel, sx(reg_file[REG_VEL_LOW]), sx(reg_file[REG_VEL_HIGH]), nv);
    res.state_index = 16'(pi * nv + vi);
    res.reward = 32'(reward_for(body_pos));
    return res;
  endfunction

  // Directed stimulus; typed results hold only where plain to see.
  function automatic dir_row_t dir_row(input int i);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd = CMD_STEP;
    case (i)
      0:  begin r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd119; end
      1:  r.data = S32_MAX;
      2:  r.data = S32_MIN;
      3:  r.data = 32'd0;
      4:  begin r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd119; end
      5:  r.data = 32'h0001_0000;
      6:  begin r.kind = ROW_WRITE; r.reg_idx = REG_REWARD_MODE; r.data = 32'(RM_DIST); end
      7:  begin
        r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd119; r.reward = -32'sd291;
      end
      8:  r.data = 32'hFFF0_0000;
      9:  begin r.kind = ROW_WRITE; r.reg_idx = REG_REWARD_MODE; r.data = 32'(RM_NORM); end
      10: begin
        r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd119; r.reward = 32'h0001_0000;
      end
      11: r.data = S32_MAX;
      12: begin r.kind = ROW_WRITE; r.reg_idx = REG_REWARD_MODE; r.data = 32'd3; end
      13: begin r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd119; end
      14: begin r.kind = ROW_WRITE; r.reg_idx = REG_POS_HIGH; r.data = 32'd0; end
      15: begin r.kind = ROW_WRITE; r.reg_idx = REG_REWARD_MODE; r.data = 32'(RM_NORM); end
      16: begin r.cmd = CMD_RESET; r.typed = 1'b1; r.state_index = 16'd247; end
      17: begin r.kind = ROW_WRITE; r.reg_idx = REG_POS_POINTS; r.data = 32'd0; end
      18: begin r.kind = ROW_WRITE; r.reg_idx = REG_VEL_POINTS; r.data = 32'h1FF; end
      19: r.data = 32'h0000_7FFF;
      // Reversed position bounds.
      20: begin r.kind = ROW_WRITE; r.reg_idx = REG_POS_LOW; r.data = 32'h0002_0000; end
      21: r.data = 32'hFFFF_0000;
      22: r.cmd = CMD_RESET;
      23: begin r.kind = ROW_WRITE; r.reg_idx = REG_START_POS; r.data = 32'h0001_8000; end
      24: r.cmd = CMD_RESET;
      default: r.data = 32'd1234567;
    endcase
    return r;
  endfunction

  // Wait until every expected result has come, then let the block settle.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Register write over the configuration port, then the model copy.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POS_POINTS, REG_VEL_POINTS: reg_file[idx] = val & 32'h1FF;
      REG_REWARD_MODE: reg_file[idx] = val & 32'h3;
      default: reg_file[idx] = val;
    endcase
  endtask

  // Offer one transaction and record its expected result on acceptance.
  task automatic send_cmd(input logic cmd, input logic [31:0] accel, input logic typed,
                          input env_result_t typed_res);
    env_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_accel <= accel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = advance_body(cmd, accel);
    if (typed) res = typed_res;
    pending_results = {pending_results, res};
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_bound(input logic up);
    logic [31:0] mag;
    mag = $urandom_range(1, 32'h0008_0000);
    return up ? mag : -mag;
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    env_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: done %0b index %0d reward %0d", $time,
                 out_done_res, out_state_index, out_reward);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_done_res !== want.done_res) begin
          $display("%0t: done_res expected %0b actual %0b", $time, want.done_res,
                   out_done_res);
          errors++;
        end
        if (out_state_index !== want.state_index) begin
          $display("%0t: state_index expected %0d actual %0d", $time, want.state_index,
                   out_state_index);
          errors++;
        end
        if (out_reward !== want.reward) begin
          $display("%0t: reward expected %0d actual %0d", $time, signed'(want.reward),
                   out_reward);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("point_mass_env_step_core: mismatch");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    dir_row_t row;
    env_result_t typed_res;
    logic [31:0] lo_val, hi_val;
    errors = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_RESET;
    in_accel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reg_file[REG_POS_LOW] = 32'hFFFF_0000;
    reg_file[REG_POS_HIGH] = 32'h0001_0000;
    reg_file[REG_VEL_LOW] = 32'hFFFF_0000;
    reg_file[REG_VEL_HIGH] = 32'h0001_0000;
    reg_file[REG_START_POS] = 32'd0;
    reg_file[REG_POS_POINTS] = 32'd16;
    reg_file[REG_VEL_POINTS] = 32'd16;
    reg_file[REG_REWARD_MODE] = 32'(RM_ENDS);
    body_pos = 0;
    body_vel = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_row(i);
      if (row.kind == ROW_WRITE) begin
        idle_input();
        drain_results();
        write_reg(row.reg_idx, row.data);
      end else begin
        typed_res.done_res = row.done_res;
        typed_res.state_index = row.state_index;
        typed_res.reward = row.reward;
        send_cmd(row.cmd, row.data, row.typed, typed_res);
      end
    end

    // Random phases, each with its own register setting and idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      idle_input();
      drain_results();
      if (ph == 0) begin
        write_reg(REG_POS_LOW, S32_MIN);
        write_reg(REG_POS_HIGH, S32_MAX);
        write_reg(REG_VEL_LOW, S32_MIN);
        write_reg(REG_VEL_HIGH, S32_MAX);
        write_reg(REG_START_POS, S32_MAX);
        write_reg(REG_POS_POINTS, 32'd256);
        write_reg(REG_VEL_POINTS, 32'd2);
      end else begin
        lo_val = rand_bound(1'b0);
        hi_val = rand_bound(1'b1);
        // Reversed bounds in one phase.
        write_reg(REG_POS_LOW, (ph == 1) ? hi_val : lo_val);
        write_reg(REG_POS_HIGH, (ph == 1) ? lo_val : hi_val);
        write_reg(REG_VEL_LOW, rand_bound(1'b0));
        write_reg(REG_VEL_HIGH, rand_bound(1'b1));
        write_reg(REG_START_POS, $urandom_range(0, 3) == 0 ? $urandom : rand_bound(ph[0]));
        write_reg(REG_POS_POINTS, (ph == 7) ? $urandom_range(0, 511) : $urandom_range(0, 24));
        write_reg(REG_VEL_POINTS, (ph == 5) ? 32'd1 : $urandom_range(2, 24));
      end
      write_reg(REG_REWARD_MODE, ph % 4);
      case (ph % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 51; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      send_cmd(CMD_RESET, $urandom, 1'b0, '0);
      for (int n = 0; n < 175; n++) begin
        // Sender holds off until the block has emptied out.
        if (ph == 3 && n == 60) begin
          idle_input();
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_cmd(($urandom_range(0, 19) == 0) ? CMD_RESET : CMD_STEP,
                 ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 32'h0020_0000)) -
                 32'h0010_0000 : $urandom, 1'b0, '0);
      end
    end

    idle_input();
    rx_stall_pct = 0;
    drain_results();
    if (errors == 0) begin
      $display("point_mass_env_step_core: match");
    end else begin
      $display("point_mass_env_step_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/pmes_pkg.sv
hdl/pmes_nearest.sv
hdl/pmes_div.sv
hdl/pmes_ctrl.sv
hdl/pmes_dp.sv
hdl/point_mass_env_step_core.sv
hdl/pmes_checker.sv
bench/point_mass_env_step_core_tb.sv
